// ===== hw/rtl/rrwl_pkg.sv =====
// Package for the recursive reader/writer lock manager.
// Holds request, status and mode codes and the controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrwl_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_NEW        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RECURSIVE  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_WAIT       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_PARTIAL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_HOLDER = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd6;

    // Lock modes
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the incoming request word, reset scan results
        logic rd_en;    // read one reader table entry
        logic commit;   // apply the decision and register the result word
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy; // result register still holds an untaken word
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/rrwl_ifs.sv =====
// Handshake channels of the lock manager: request and response.
// Depends on rrwl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrwl_req_if
    import rrwl_pkg::*;
#(
    parameter int ID_W = 8
);
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   requester;

    modport source (output valid, kind, requester, input ready);
    modport sink   (input valid, kind, requester, output ready);
endinterface

interface rrwl_rsp_if
    import rrwl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                wake_waiters;
    logic [MODE_W-1:0]   lock_mode;

    modport source (output valid, status, wake_waiters, lock_mode, input ready);
    modport sink   (input valid, status, wake_waiters, lock_mode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/recursive_reader_writer_lock.sv =====
// Top level of the recursive reader/writer lock manager.
// Depends on rrwl_pkg, rrwl_ifs, rrwl_ctrl and rrwl_dp.
//
//   channel   dir   fields                                  handshake
//   i_req     in    kind[1:0], requester[REQUESTER_BITS-1:0] valid/ready
//   o_rsp     out   status[2:0], wake_waiters, lock_mode[1:0] valid/ready
//
// Each request is accepted, then the reader table entries are read one address at a time
// through the table RAM read ports, the last read is left to return, and the result is
// committed once the output register is free.
// Synchronous active-low reset clears the writer state, the waiting flag and
// the slot valid bits at once; the table RAMs need no clearing pass.
// The result sits in an output register; a new request is accepted while it
// waits, and that request's commit holds until the earlier word is taken.
`timescale 1ns / 1ps
`default_nettype none

module recursive_reader_writer_lock
    import rrwl_pkg::*;
#(
    parameter int MAX_READERS    = 16,
    parameter int REQUESTER_BITS = 8,
    parameter int COUNT_BITS     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrwl_req_if.sink  i_req,
    rrwl_rsp_if.source o_rsp
);

    localparam int IDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [IDX_W-1:0] w_rd_addr;

    rrwl_ctrl #(
        .MAX_READERS (MAX_READERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    rrwl_dp #(
        .MAX_READERS    (MAX_READERS),
        .REQUESTER_BITS (REQUESTER_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .o_stat         (w_stat),
        .i_kind         (i_req.kind),
        .i_requester    (i_req.requester),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_wake_waiters (o_rsp.wake_waiters),
        .o_lock_mode    (o_rsp.lock_mode)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rrwl_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rrwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/rrwl_ctrl.sv =====
// Controller of the lock manager: accepts a request word, walks the reader
// table address by address and commits the result. Depends on rrwl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrwl_ctrl
    import rrwl_pkg::*;
#(
    parameter int MAX_READERS = 16,
    parameter int IDX_W       = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_dp_stat         i_stat,
    output t_dp_cmd               o_cmd,
    output logic      [IDX_W-1:0] o_rd_addr
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_ctl_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_READERS - 1);

    t_ctl_state       r_state, n_state;
    logic [IDX_W-1:0] r_scan, n_scan;

    // Sequence one request through scan, drain and commit
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_scan     = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_scan      = r_scan + 1'b1;
                if (r_scan == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr = r_scan;

    // Hold state and scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrwl_dp.sv =====
// Datapath of the lock manager: writer state, reader table (RAMs plus
// valid bits), scan results, decision logic and the result register.
// Depends on rrwl_pkg and rrwl_ram.
`timescale 1ns / 1ps
`default_nettype none

module rrwl_dp
    import rrwl_pkg::*;
#(
    parameter int MAX_READERS    = 16,
    parameter int REQUESTER_BITS = 8,
    parameter int COUNT_BITS     = 16,
    parameter int IDX_W          = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    input  wire logic [IDX_W-1:0]          i_rd_addr,
    output t_dp_stat                       o_stat,
    input  wire logic [KIND_W-1:0]         i_kind,
    input  wire logic [REQUESTER_BITS-1:0] i_requester,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [STATUS_W-1:0]       o_status,
    output logic                           o_wake_waiters,
    output logic      [MODE_W-1:0]         o_lock_mode
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Request word
    logic [KIND_W-1:0]         r_kind;
    logic [REQUESTER_BITS-1:0] r_who;

    // Lock state
    logic                      r_wr_held, n_wr_held;
    logic [REQUESTER_BITS-1:0] r_wr_owner, n_wr_owner;
    logic [COUNT_BITS-1:0]     r_wr_depth, n_wr_depth;
    logic [MAX_READERS-1:0]    r_slot_vld, n_slot_vld;
    logic                      r_waiting, n_waiting;

    // Scan pipeline and results
    logic                  r_chk_en;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_hit_fnd;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_free_fnd;
    logic [IDX_W-1:0]      r_free_idx;

    // Result register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status, n_status;
    logic                r_out_wake, n_wake;
    logic [MODE_W-1:0]   r_out_mode, n_mode;

    // Table write port
    logic                      w_tbl_we;
    logic                      w_id_we;
    logic [IDX_W-1:0]          w_tbl_addr;
    logic [COUNT_BITS-1:0]     w_cnt_wdata;
    logic [REQUESTER_BITS-1:0] w_id_rdata;
    logic [COUNT_BITS-1:0]     w_cnt_rdata;
    logic                      w_any_rd;
    logic [MAX_READERS-1:0]    w_left_vld;

    rrwl_ram #(
        .WIDTH (REQUESTER_BITS),
        .DEPTH (MAX_READERS)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_id_we),
        .i_wr_addr (w_tbl_addr),
        .i_wr_data (r_who),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_id_rdata)
    );

    rrwl_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_READERS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_tbl_we),
        .i_wr_addr (w_tbl_addr),
        .i_wr_data (w_cnt_wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_cnt_rdata)
    );

    assign w_any_rd = |r_slot_vld;

    // Readers left once the hit slot is dropped
    always_comb begin
        w_left_vld            = r_slot_vld;
        w_left_vld[r_hit_idx] = 1'b0;
    end

    // Decide the result and the next lock state
    always_comb begin
        n_wr_held   = r_wr_held;
        n_wr_owner  = r_wr_owner;
        n_wr_depth  = r_wr_depth;
        n_slot_vld  = r_slot_vld;
        n_waiting   = r_waiting;
        n_status    = STAT_NOT_HOLDER;
        n_wake      = 1'b0;
        w_tbl_we    = 1'b0;
        w_id_we     = 1'b0;
        w_tbl_addr  = r_hit_idx;
        w_cnt_wdata = r_hit_cnt;
        unique case (r_kind)
            KIND_READ: begin
                if (r_wr_held) begin
                    n_status  = STAT_WAIT;
                    n_waiting = 1'b1;
                end else if (r_hit_fnd) begin
                    if (r_hit_cnt == '1) begin
                        n_status = STAT_OVERFLOW;
                    end else begin
                        w_tbl_we    = 1'b1;
                        w_cnt_wdata = r_hit_cnt + CNT_ONE;
                        n_status    = STAT_RECURSIVE;
                    end
                end else if (r_free_fnd) begin
                    w_tbl_we               = 1'b1;
                    w_id_we                = 1'b1;
                    w_tbl_addr             = r_free_idx;
                    w_cnt_wdata            = CNT_ONE;
                    n_slot_vld[r_free_idx] = 1'b1;
                    n_status               = STAT_NEW;
                end else begin
                    n_status = STAT_OVERFLOW;
                end
            end
            KIND_WRITE: begin
                if (r_wr_held && r_wr_owner == r_who) begin
                    if (r_wr_depth == '1) begin
                        n_status = STAT_OVERFLOW;
                    end else begin
                        n_wr_depth = r_wr_depth + CNT_ONE;
                        n_status   = STAT_RECURSIVE;
                    end
                end else if (r_wr_held || w_any_rd) begin
                    n_status  = STAT_WAIT;
                    n_waiting = 1'b1;
                end else begin
                    n_wr_held  = 1'b1;
                    n_wr_owner = r_who;
                    n_wr_depth = CNT_ONE;
                    n_status   = STAT_NEW;
                end
            end
            KIND_UNLOCK: begin
                if (r_wr_held) begin
                    if (r_wr_owner != r_who) begin
                        n_status = STAT_NOT_HOLDER;
                    end else if (r_wr_depth > CNT_ONE) begin
                        n_wr_depth = r_wr_depth - CNT_ONE;
                        n_status   = STAT_PARTIAL;
                    end else begin
                        n_wr_held  = 1'b0;
                        n_wr_owner = '0;
                        n_wr_depth = '0;
                        n_status   = STAT_FULL;
                        n_wake     = r_waiting;
                        n_waiting  = 1'b0;
                    end
                end else if (w_any_rd) begin
                    if (!r_hit_fnd) begin
                        n_status = STAT_NOT_HOLDER;
                    end else if (r_hit_cnt > CNT_ONE) begin
                        w_tbl_we    = 1'b1;
                        w_cnt_wdata = r_hit_cnt - CNT_ONE;
                        n_status    = STAT_PARTIAL;
                    end else begin
                        n_slot_vld = w_left_vld;
                        n_status   = STAT_FULL;
                        if (w_left_vld == '0) begin
                            n_wake    = r_waiting;
                            n_waiting = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_status = STAT_NOT_HOLDER;
            end
        endcase
        if (!i_cmd.commit) begin
            w_tbl_we = 1'b0;
            w_id_we  = 1'b0;
        end
        n_mode = n_wr_held ? MODE_WRITE : ((|n_slot_vld) ? MODE_READ : MODE_FREE);
    end

    // Capture the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_who  <= i_requester;
        end
    end

    // Track the first matching slot and the first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_en   <= 1'b0;
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
        end else begin
            r_chk_en <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_hit_fnd  <= 1'b0;
                r_free_fnd <= 1'b0;
            end else if (r_chk_en) begin
                if (r_slot_vld[r_chk_idx] && w_id_rdata == r_who && !r_hit_fnd) begin
                    r_hit_fnd <= 1'b1;
                end
                if (!r_slot_vld[r_chk_idx] && !r_free_fnd) begin
                    r_free_fnd <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= i_rd_addr;
        if (r_chk_en && r_slot_vld[r_chk_idx] && w_id_rdata == r_who && !r_hit_fnd) begin
            r_hit_idx <= r_chk_idx;
            r_hit_cnt <= w_cnt_rdata;
        end
        if (r_chk_en && !r_slot_vld[r_chk_idx] && !r_free_fnd) begin
            r_free_idx <= r_chk_idx;
        end
    end

    // Apply the decision on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_held  <= 1'b0;
            r_wr_owner <= '0;
            r_wr_depth <= '0;
            r_slot_vld <= '0;
            r_waiting  <= 1'b0;
        end else if (i_cmd.commit) begin
            r_wr_held  <= n_wr_held;
            r_wr_owner <= n_wr_owner;
            r_wr_depth <= n_wr_depth;
            r_slot_vld <= n_slot_vld;
            r_waiting  <= n_waiting;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_wake   <= n_wake;
            r_out_mode   <= n_mode;
        end
    end

    assign o_stat.out_busy = r_out_vld && !i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_wake_waiters  = r_out_wake;
    assign o_lock_mode     = r_out_mode;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the recursive reader/writer lock manager.
// Depends on rrwl_pkg, rrwl_ifs and the recursive_reader_writer_lock top level.
// A shadow lock table predicts every reply; the driver runs on the falling edge and the monitor on the rising edge.
`timescale 1ns / 1ps

module tb_top;
    import rrwl_pkg::*;

    localparam int MAX_RD = 16;
    localparam int ID_W   = 8;
    // Full-width hold counters; deep nesting stays well below the count limit
    localparam int CNT_W   = 16;
    localparam int CNT_TOP = (1 << CNT_W) - 1;
    localparam int DEEP_LO = 12;
    localparam int DEEP_HI = 24;

    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
    localparam int N_RANDOM = 1200;
    localparam int MAX_SHOWN = 10;

    // Two copies of the lock table: one steers stimulus, one predicts replies
    localparam int GEN = 0;
    localparam int CHK = 1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   who;
    } t_lock_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wake;
        logic [MODE_W-1:0]   mode;
    } t_lock_reply;

    typedef enum int {
        SC_READERS,
        SC_WRITER,
        SC_DEEP_READER,
        SC_TABLE,
        SC_NOISE
    } t_scenario;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic              drv_valid = 1'b0;
    logic [KIND_W-1:0] drv_kind  = '0;
    logic [ID_W-1:0]   drv_who   = '0;
    logic              drv_ready = 1'b0;

    rrwl_req_if #(.ID_W(ID_W)) req_if ();
    rrwl_rsp_if                rsp_if ();

    assign req_if.valid     = drv_valid;
    assign req_if.kind      = drv_kind;
    assign req_if.requester = drv_who;
    assign rsp_if.ready     = drv_ready;

    recursive_reader_writer_lock #(
        .MAX_READERS   (MAX_RD),
        .REQUESTER_BITS(ID_W),
        .COUNT_BITS    (CNT_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow lock state, one row per copy
    logic             w_held   [2];
    logic [ID_W-1:0]  w_owner  [2];
    logic [CNT_W-1:0] w_depth  [2];
    int               n_readers[2];
    logic [ID_W-1:0]  slot_id  [2][MAX_RD];
    logic [CNT_W-1:0] slot_cnt [2][MAX_RD];
    logic             waiting  [2];

    t_lock_req   request_q[$];
    t_lock_reply reply_q[$];

    int total_items = 0;
    int gen_items   = 0;
    int n_accepted  = 0;
    int n_replied   = 0;
    int mismatches  = 0;
    int drv_seen    = 0;
    int stat_count [8];
    int wake_count  = 0;
    bit stim_ready  = 1'b0;

    // Clock: 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void lock_clear(input int m);
        w_held[m]    = 1'b0;
        w_owner[m]   = '0;
        w_depth[m]   = '0;
        n_readers[m] = 0;
        waiting[m]   = 1'b0;
        for (int i = 0; i < MAX_RD; i++) begin
            slot_id[m][i]  = '0;
            slot_cnt[m][i] = '0;
        end
    endfunction

    function automatic int find_reader(input int m, input logic [ID_W-1:0] who);
        for (int i = 0; i < MAX_RD; i++) begin
            if (slot_cnt[m][i] != 0 && slot_id[m][i] == who) return i;
        end
        return -1;
    endfunction

    function automatic int find_free(input int m);
        for (int i = 0; i < MAX_RD; i++) begin
            if (slot_cnt[m][i] == 0) return i;
        end
        return -1;
    endfunction

    // Apply one request to a copy of the lock table and return its reply
    function automatic t_lock_reply lock_apply(input int m, input logic [KIND_W-1:0] kind,
                                               input logic [ID_W-1:0] who);
        t_lock_reply r;
        int s;
        r.status = STAT_NOT_HOLDER;
        r.wake   = 1'b0;
        case (kind)
            KIND_READ: begin
                if (w_held[m]) begin
                    r.status   = STAT_WAIT;
                    waiting[m] = 1'b1;
                end else begin
                    s = find_reader(m, who);
                    if (s >= 0) begin
                        if (slot_cnt[m][s] == CNT_W'(CNT_TOP)) begin
                            r.status = STAT_OVERFLOW;
                        end else begin
                            slot_cnt[m][s] = slot_cnt[m][s] + 1'b1;
                            r.status = STAT_RECURSIVE;
                        end
                    end else begin
                        s = find_free(m);
                        if (s < 0) begin
                            r.status = STAT_OVERFLOW;
                        end else begin
                            slot_id[m][s]  = who;
                            slot_cnt[m][s] = CNT_W'(1);
                            n_readers[m]   = n_readers[m] + 1;
                            r.status = STAT_NEW;
                        end
                    end
                end
            end
            KIND_WRITE: begin
                if (w_held[m] && w_owner[m] == who) begin
                    if (w_depth[m] == CNT_W'(CNT_TOP)) begin
                        r.status = STAT_OVERFLOW;
                    end else begin
                        w_depth[m] = w_depth[m] + 1'b1;
                        r.status = STAT_RECURSIVE;
                    end
                end else if (w_held[m] || n_readers[m] != 0) begin
                    r.status   = STAT_WAIT;
                    waiting[m] = 1'b1;
                end else begin
                    w_held[m]  = 1'b1;
                    w_owner[m] = who;
                    w_depth[m] = CNT_W'(1);
                    r.status = STAT_NEW;
                end
            end
            KIND_UNLOCK: begin
                if (w_held[m]) begin
                    if (w_owner[m] != who) begin
                        r.status = STAT_NOT_HOLDER;
                    end else if (w_depth[m] > 1) begin
                        w_depth[m] = w_depth[m] - 1'b1;
                        r.status = STAT_PARTIAL;
                    end else begin
                        w_depth[m] = '0;
                        w_held[m]  = 1'b0;
                        w_owner[m] = '0;
                        r.status   = STAT_FULL;
                        r.wake     = waiting[m];
                        waiting[m] = 1'b0;
                    end
                end else if (n_readers[m] != 0) begin
                    s = find_reader(m, who);
                    if (s < 0) begin
                        r.status = STAT_NOT_HOLDER;
                    end else if (slot_cnt[m][s] > 1) begin
                        slot_cnt[m][s] = slot_cnt[m][s] - 1'b1;
                        r.status = STAT_PARTIAL;
                    end else begin
                        slot_cnt[m][s] = '0;
                        n_readers[m]   = n_readers[m] - 1;
                        r.status = STAT_FULL;
                        if (n_readers[m] == 0) begin
                            r.wake     = waiting[m];
                            waiting[m] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.mode = w_held[m] ? MODE_WRITE : (n_readers[m] != 0 ? MODE_READ : MODE_FREE);
        return r;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom);
    endfunction

    // Queue one request and advance the stimulus copy of the table
    function automatic void queue_req(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] who);
        t_lock_req q;
        q.kind = kind;
        q.who  = who;
        request_q.push_back(q);
        void'(lock_apply(GEN, kind, who));
        if (kind != KIND_BAD) gen_items = gen_items + 1;
    endfunction

    // Drop every hold that the stimulus copy still sees
    function automatic void release_all();
        int c;
        int off;
        int s;
        logic [ID_W-1:0] id;
        if (w_held[GEN]) begin
            id = w_owner[GEN];
            c  = int'(w_depth[GEN]);
            repeat (c) queue_req(KIND_UNLOCK, id);
        end
        off = $urandom_range(0, MAX_RD - 1);
        for (int i = 0; i < MAX_RD; i++) begin
            s = (i + off) % MAX_RD;
            if (slot_cnt[GEN][s] != 0) begin
                id = slot_id[GEN][s];
                c  = int'(slot_cnt[GEN][s]);
                repeat (c) queue_req(KIND_UNLOCK, id);
            end
        end
    endfunction

    // Contend with the current holder
    function automatic void interfere(input logic [ID_W-1:0] own);
        case ($urandom_range(0, 4))
            0: queue_req(KIND_WRITE, own);
            1: queue_req(KIND_READ, own);
            2: queue_req(KIND_WRITE, rand_id());
            3: queue_req(KIND_READ, rand_id());
            default: queue_req(KIND_UNLOCK, rand_id());
        endcase
    endfunction

    function automatic void gen_readers();
        logic [ID_W-1:0] ids [6];
        int left [6];
        int held [6];
        int n;
        int r;
        int busy;
        n    = $urandom_range(1, 6);
        busy = 0;
        for (int i = 0; i < n; i++) begin
            ids[i]  = rand_id();
            left[i] = $urandom_range(1, 4);
            held[i] = 0;
            busy    = busy + left[i];
        end
        while (busy > 0) begin
            r = $urandom_range(0, n - 1);
            if (left[r] > 0 && (held[r] == 0 || $urandom_range(0, 1) == 1)) begin
                queue_req(KIND_READ, ids[r]);
                left[r] -= 1;
                held[r] += 1;
            end else if (held[r] > 0) begin
                queue_req(KIND_UNLOCK, ids[r]);
                held[r] -= 1;
                busy    -= 1;
            end
            if ($urandom_range(0, 7) == 0) interfere(ids[r]);
        end
    endfunction

    function automatic void gen_writer(input bit deep);
        logic [ID_W-1:0] w;
        int d;
        w = rand_id();
        d = deep ? $urandom_range(DEEP_LO, DEEP_HI) : $urandom_range(1, 4);
        for (int i = 0; i < d; i++) begin
            queue_req(KIND_WRITE, w);
            if ($urandom_range(0, 3) == 0) interfere(w);
        end
        repeat (d + $urandom_range(0, 1)) begin
            queue_req(KIND_UNLOCK, w);
            if ($urandom_range(0, 5) == 0) interfere(w);
        end
    endfunction

    function automatic void gen_deep_reader();
        logic [ID_W-1:0] r;
        r = rand_id();
        repeat ($urandom_range(DEEP_LO, DEEP_HI)) begin
            queue_req(KIND_READ, r);
            if ($urandom_range(0, 5) == 0) interfere(r);
        end
    endfunction

    // Fill every reader slot, then try more new readers, a recursive read and a write
    function automatic void gen_table();
        logic [ID_W-1:0] base;
        base = rand_id();
        for (int i = 0; i < MAX_RD + 2; i++) queue_req(KIND_READ, base + ID_W'(i));
        queue_req(KIND_READ, base);
        queue_req(KIND_WRITE, base);
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(3, 8)) queue_req(KIND_W'($urandom), rand_id());
    endfunction

    function automatic t_scenario pick_scenario();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return SC_READERS;
        if (p < 65) return SC_WRITER;
        if (p < 85) return SC_NOISE;
        if (p < 93) return SC_DEEP_READER;
        return SC_TABLE;
    endfunction

    function automatic int phase_of();
        return (n_accepted * 3) / total_items;
    endfunction

    // Build all stimulus up front: directed cases, then random scenarios
    initial begin
        int target;
        int k;
        t_scenario sc;
        lock_clear(GEN);
        lock_clear(CHK);
        for (int i = 0; i < 8; i++) stat_count[i] = 0;

        // Directed: free unlock, ignored kind, reader sharing, waits, wakes
        queue_req(KIND_UNLOCK, 8'd0);
        queue_req(KIND_BAD, 8'd255);
        queue_req(KIND_READ, 8'd0);
        queue_req(KIND_READ, 8'd0);
        queue_req(KIND_READ, 8'd255);
        queue_req(KIND_WRITE, 8'd255);
        queue_req(KIND_WRITE, 8'd7);
        queue_req(KIND_UNLOCK, 8'd9);
        queue_req(KIND_UNLOCK, 8'd0);
        queue_req(KIND_UNLOCK, 8'd0);
        queue_req(KIND_UNLOCK, 8'd255);
        queue_req(KIND_WRITE, 8'd255);
        queue_req(KIND_WRITE, 8'd255);
        queue_req(KIND_READ, 8'd255);
        queue_req(KIND_WRITE, 8'd0);
        queue_req(KIND_UNLOCK, 8'd0);
        queue_req(KIND_UNLOCK, 8'd255);
        queue_req(KIND_UNLOCK, 8'd255);
        queue_req(KIND_WRITE, 8'd0);
        queue_req(KIND_UNLOCK, 8'd0);
        queue_req(KIND_UNLOCK, 8'd0);

        // Random: table full and deep nesting first, then a weighted mix
        target = gen_items + N_RANDOM;
        k = 0;
        while (gen_items < target) begin
            case (k)
                0: sc = SC_TABLE;
                1: sc = SC_WRITER;
                2: sc = SC_DEEP_READER;
                default: sc = pick_scenario();
            endcase
            case (sc)
                SC_READERS:     gen_readers();
                SC_WRITER:      gen_writer(k == 1 || $urandom_range(0, 4) == 0);
                SC_DEEP_READER: gen_deep_reader();
                SC_TABLE:       gen_table();
                default:        gen_noise();
            endcase
            if (k < 3 || $urandom_range(0, 99) < 85) release_all();
            k = k + 1;
        end
        release_all();
        total_items = request_q.size();
        stim_ready  = 1'b1;
    end

    // Reset: hold low, then release on a falling clock edge
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request driver: present the next word once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && stim_ready) begin
            if (!drv_valid || n_accepted != drv_seen) begin
                drv_seen = n_accepted;
                if (request_q.size() != 0 &&
                    $urandom_range(0, 99) >= (phase_of() == 0 ? 9 :
                                              phase_of() == 1 ? 46 : 0)) begin
                    drv_valid <= 1'b1;
                    drv_kind  <= request_q[0].kind;
                    drv_who   <= request_q[0].who;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Reply sink: stall at random per phase
    always @(negedge i_clk) begin
        if (i_rst_n && stim_ready) begin
            drv_ready <= $urandom_range(0, 99) >= (phase_of() == 0 ? 46 :
                                                   phase_of() == 1 ? 9 : 0);
        end
    end

    // Predict on each accepted request, check each accepted reply
    always @(posedge i_clk) begin
        t_lock_reply pred;
        t_lock_reply got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pred = lock_apply(CHK, req_if.kind, req_if.requester);
                reply_q.push_back(pred);
                stat_count[pred.status] = stat_count[pred.status] + 1;
                if (pred.wake) wake_count = wake_count + 1;
                void'(request_q.pop_front());
                n_accepted = n_accepted + 1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got.status = rsp_if.status;
                got.wake   = rsp_if.wake_waiters;
                got.mode   = rsp_if.lock_mode;
                n_replied  = n_replied + 1;
                if (reply_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: reply with none pending: status %0d wake %0d mode %0d",
                                 $time, got.status, got.wake, got.mode);
                end else begin
                    pred = reply_q.pop_front();
                    if (got !== pred) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: reply %0d: status %0d/%0d wake %0d/%0d mode %0d/%0d %s",
                                     $time, n_replied, pred.status, got.status, pred.wake,
                                     got.wake, pred.mode, got.mode, "(expected/actual)");
                    end
                end
            end
        end
    end

    // End of run: drain, settle, report
    initial begin
        wait (stim_ready);
        wait (n_accepted == total_items && n_replied >= n_accepted);
        repeat (2 * (MAX_RD + 3)) @(posedge i_clk);
        $display("covered %0d requests: %0d new, %0d recursive, %0d waits, %0d partial, %0d full",
                 n_accepted, stat_count[STAT_NEW], stat_count[STAT_RECURSIVE],
                 stat_count[STAT_WAIT], stat_count[STAT_PARTIAL], stat_count[STAT_FULL]);
        $display("  %0d not-holder, %0d table-full/overflow, %0d wakeups, %0d mismatches",
                 stat_count[STAT_NOT_HOLDER], stat_count[STAT_OVERFLOW], wake_count, mismatches);
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("recursive_reader_writer_lock regression: pass");
        end else begin
            $display("recursive_reader_writer_lock regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("timeout after %0d of %0d requests", n_accepted, total_items);
        $display("recursive_reader_writer_lock regression: fail");
        $finish;
    end

endmodule
